// File: rtl/core/wave_equation_stencil_step_assert.svh
// Assertion macros for the wave stencil RTL.
`ifndef WAVE_EQUATION_STENCIL_STEP_ASSERT_SVH
`define WAVE_EQUATION_STENCIL_STEP_ASSERT_SVH

// Same-cycle implication.
`define WES_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wes: same-cycle check failed");

// Next-cycle implication.
`define WES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wes: next-cycle check failed");

`endif

// File: rtl/core/wes_pkg.sv
// Package: widths, codes and types of the wave stencil step block.
`default_nettype none

package wes_pkg;

  localparam int MAX_SIDE_DEF = 64;

  localparam int DATA_W     = 32;
  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 6;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 14;
  localparam int MIN_INNER  = 2;

  // Datapath widths of the stencil arithmetic.
  localparam int LAP_W  = DATA_W + 3;
  localparam int BASE_W = DATA_W + 2;
  localparam int PROD_W = LAP_W + COEF_W + 1;
  localparam int SUM_W  = PROD_W - COEF_FRAC + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT    = 1'd1;

  localparam logic [SIZE_W-1:0] INNER_SIZE_RST = 6'd62;
  localparam logic [COEF_W-1:0] COURANT_RST    = 16'd7783;

  // Item kinds.
  localparam logic ACT_CELL  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Where the new cell value comes from.
  typedef enum logic [2:0] {
    SEL_DRIVE,
    SEL_DOWN,
    SEL_RIGHT,
    SEL_UP,
    SEL_LEFT,
    SEL_STENCIL
  } sel_t;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] cur_value;
    logic signed [DATA_W-1:0] prior_value;
    logic signed [DATA_W-1:0] drive_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] next_value;
    logic [COORD_W-1:0]       out_row;
    logic [COORD_W-1:0]       out_col;
    logic                     last_of_frame;
  } result_t;

  typedef struct packed {
    sel_t               sel;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last;
  } sten_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/wes_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`default_nettype none

interface wes_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wes_line_cell.sv
// Line cell: one row-deep line memory, one write port, two registered reads.
`default_nettype none

module wes_line_cell #(
  parameter int DEPTH = wes_pkg::MAX_SIDE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    wr_addr,
  input  logic signed [wes_pkg::DATA_W-1:0] wr_data,
  input  logic                             re,
  input  logic [AW-1:0]                    rd_addr_a,
  input  logic [AW-1:0]                    rd_addr_b,
  output logic signed [wes_pkg::DATA_W-1:0] rd_data_a,
  output logic signed [wes_pkg::DATA_W-1:0] rd_data_b
);

  logic signed [wes_pkg::DATA_W-1:0] mem [DEPTH];

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wes_stencil_alu.sv
// Stencil arithmetic: Laplacian, coefficient multiply, floor shift, saturation.
`default_nettype none

module wes_stencil_alu (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  wes_pkg::sten_ctrl_t               ctrl,
  input  logic signed [wes_pkg::DATA_W-1:0] left,
  input  logic signed [wes_pkg::DATA_W-1:0] right,
  input  logic signed [wes_pkg::DATA_W-1:0] center,
  input  logic signed [wes_pkg::DATA_W-1:0] up,
  input  logic signed [wes_pkg::DATA_W-1:0] down,
  input  logic signed [wes_pkg::DATA_W-1:0] prior,
  input  logic signed [wes_pkg::DATA_W-1:0] drive,
  input  logic [wes_pkg::COEF_W-1:0]        coeff,
  output logic                              out_valid,
  output wes_pkg::result_t                  result
);

  localparam int DW = wes_pkg::DATA_W;
  localparam int LW = wes_pkg::LAP_W;
  localparam int BW = wes_pkg::BASE_W;
  localparam int PW = wes_pkg::PROD_W;
  localparam int SW = wes_pkg::SUM_W;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // stage A: Laplacian and 2u - um
  logic                    valid_a;
  wes_pkg::sten_ctrl_t     ctrl_a;
  logic signed [LW-1:0]    lap_a;
  logic signed [BW-1:0]    base_a;
  logic signed [DW-1:0]    direct_a;
  logic signed [LW-1:0]    lap_next;
  logic signed [BW-1:0]    base_next;
  logic signed [DW-1:0]    direct_next;

  // stage B: product
  logic                    valid_b;
  wes_pkg::sten_ctrl_t     ctrl_b;
  logic signed [PW-1:0]    prod_b;
  logic signed [BW-1:0]    base_b;
  logic signed [DW-1:0]    direct_b;

  // stage C: add and clamp
  logic signed [SW-1:0]    sum_c;
  logic signed [DW-1:0]    sat_c;

  always_comb begin
    lap_next  = LW'(left) + LW'(right) + LW'(up) + LW'(down) - (LW'(center) <<< 2);
    base_next = BW'(center) + BW'(center) - BW'(prior);
    case (ctrl.sel)
      wes_pkg::SEL_DRIVE: direct_next = drive;
      wes_pkg::SEL_DOWN:  direct_next = down;
      wes_pkg::SEL_RIGHT: direct_next = right;
      wes_pkg::SEL_UP:    direct_next = up;
      wes_pkg::SEL_LEFT:  direct_next = left;
      default:            direct_next = '0;
    endcase
  end

  always_comb begin
    sum_c = SW'(base_b) + SW'(prod_b >>> wes_pkg::COEF_FRAC);
    if (sum_c > SAT_HI) begin
      sat_c = SAT_HI[DW-1:0];
    end else if (sum_c < SAT_LO) begin
      sat_c = SAT_LO[DW-1:0];
    end else begin
      sat_c = sum_c[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_a   <= ctrl;
      lap_a    <= lap_next;
      base_a   <= base_next;
      direct_a <= direct_next;

      ctrl_b   <= ctrl_a;
      prod_b   <= lap_a * $signed({1'b0, coeff});
      base_b   <= base_a;
      direct_b <= direct_a;

      result.next_value    <= (ctrl_b.sel == wes_pkg::SEL_STENCIL) ? sat_c : direct_b;
      result.out_row       <= ctrl_b.out_row;
      result.out_col       <= ctrl_b.out_col;
      result.last_of_frame <= ctrl_b.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wave_equation_stencil_step.sv
// Top level: one time step of the 2-D wave equation over a streamed square grid.
`default_nettype none

`include "wave_equation_stencil_step_assert.svh"

// Cells of a (inner_size+2) square grid, border included, arrive in raster
// order, one per transaction on items; a frame ends with one row of flush
// transactions (action = 1) that drains the last row. Results trail the input
// by one grid row: the cell at (r, c) produces the new value of (r-1, c), so
// grid row 0 produces nothing and the flush row produces the bottom row, its
// final cell flagged by last_of_frame. The block takes one transaction per
// clock with no gaps between rows or frames, unless the results register is
// full and not being taken. A transaction passes a read stage, the Laplacian,
// the coefficient multiply and the shift/saturate stage on its way to the
// results register. Each line memory has one write port advancing one column
// per taken transaction. The three line memories (row above, two rows above,
// previous values of the row above) hold the rows; the row-above cell's old
// entry moves into the two-rows-above cell from the read stage.
// A flush transaction while grid rows remain, or a cell while the flush row is
// due, is taken and dropped. inner_size (clamped to 2..MAX_SIDE-2) and
// courant_coeff may be written only while no transaction is in flight; the
// oscillator cells on the diagonal at inner_size/4 and 3*(inner_size/4) take
// the drive value sampled with the frame's first cell.
module wave_equation_stencil_step #(
  parameter int MAX_SIDE = wes_pkg::MAX_SIDE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  wes_stream_if.sink                         items,
  wes_stream_if.source                       results,
  input  logic                               cfg_write,
  input  logic [wes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DW = wes_pkg::DATA_W;
  localparam int CW = $clog2(MAX_SIDE);
  localparam int RW = $clog2(MAX_SIDE + 1);
  // position arithmetic wide enough for both the counters and the size register
  localparam int PW = (RW > wes_pkg::SIZE_W + 1) ? RW : wes_pkg::SIZE_W + 1;

  localparam logic [PW-1:0] M_LO = PW'(wes_pkg::MIN_INNER);
  localparam logic [PW-1:0] M_HI = PW'(MAX_SIDE - 2);

  typedef struct packed {
    wes_pkg::sten_ctrl_t  ctrl;
    logic                 emit;
    logic                 store_write;
    logic                 right_ok;
    logic [CW-1:0]        col;
    logic signed [DW-1:0] down;
    logic signed [DW-1:0] drive;
  } stage1_t;

  // configuration registers
  logic [wes_pkg::SIZE_W-1:0] inner_size;
  logic [wes_pkg::COEF_W-1:0] courant_coeff;

  // frame position and latched state
  logic [RW-1:0]        row_counter, row_counter_next;
  logic [CW-1:0]        col_counter, col_counter_next;
  logic signed [DW-1:0] drive_latch;
  logic signed [DW-1:0] left_above;

  // read stage
  logic    stage1_valid;
  stage1_t stage1, stage1_next;

  // line cell read data
  logic signed [DW-1:0] above_rd_a, above_rd_b;
  logic signed [DW-1:0] two_rd_a;
  logic signed [DW-1:0] prior_rd_a;

  logic signed [DW-1:0] right_val;

  // geometry
  logic [PW-1:0] size_ext, m_eff, side, quarter, three_q;
  logic [PW-1:0] row_x, col_x, r_eff, c_eff, col_inc, row_inc, o_pos;
  logic          oor, flush_row, is_flush, accept, take, wrap, first_cell, osc;
  logic          adv;

  logic                 alu_valid;
  wes_pkg::result_t     alu_result;

  // --------------------------------------------------------------------
  // Handshake: everything moves together unless the results register is
  // full and not being taken.
  // --------------------------------------------------------------------
  assign adv         = !results.valid || results.ready;
  assign items.ready = adv;
  assign accept      = items.valid && items.ready;

  // --------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_size    <= wes_pkg::INNER_SIZE_RST;
      courant_coeff <= wes_pkg::COURANT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wes_pkg::REG_INNER_SIZE: inner_size    <= cfg_data[wes_pkg::SIZE_W-1:0];
        wes_pkg::REG_COURANT:    courant_coeff <= cfg_data[wes_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped interior size, full side and the oscillator diagonal positions.
  always_comb begin
    size_ext = PW'(inner_size);
    if (size_ext < M_LO) begin
      m_eff = M_LO;
    end else if (size_ext > M_HI) begin
      m_eff = M_HI;
    end else begin
      m_eff = size_ext;
    end
    side    = m_eff + PW'(2);
    quarter = m_eff >> 2;
    three_q = quarter + (quarter << 1);
  end

  // --------------------------------------------------------------------
  // Raster position. Counters left outside the grid by a size change
  // restart at the top-left corner.
  // --------------------------------------------------------------------
  always_comb begin
    row_x     = PW'(row_counter);
    col_x     = PW'(col_counter);
    oor       = (row_x > side) || (col_x >= side);
    r_eff     = oor ? '0 : row_x;
    c_eff     = oor ? '0 : col_x;
    flush_row = (r_eff == side);
    is_flush  = (items.data.action == wes_pkg::ACT_FLUSH);
    take      = accept && (is_flush == flush_row);
    col_inc   = c_eff + PW'(1);
    row_inc   = r_eff + PW'(1);
    wrap      = (col_inc >= side);
    o_pos     = r_eff - PW'(1);

    row_counter_next = row_counter;
    col_counter_next = col_counter;
    if (take) begin
      if (wrap) begin
        col_counter_next = '0;
        row_counter_next = (row_inc > side) ? '0 : row_inc[RW-1:0];
      end else begin
        col_counter_next = col_inc[CW-1:0];
        row_counter_next = r_eff[RW-1:0];
      end
    end else if (accept && oor) begin
      col_counter_next = '0;
      row_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
    end else begin
      row_counter <= row_counter_next;
      col_counter <= col_counter_next;
    end
  end

  // Drive value for the oscillators, sampled with the frame's first cell.
  assign first_cell = !flush_row && (r_eff == '0) && (c_eff == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_latch <= '0;
    end else if (take && first_cell) begin
      drive_latch <= items.data.drive_value;
    end
  end

  // --------------------------------------------------------------------
  // Output cell classification, done at the read stage. Precedence:
  // oscillator, top border, left border, bottom border, right border,
  // then the interior stencil.
  // --------------------------------------------------------------------
  assign osc = (o_pos == c_eff) && ((o_pos == quarter) || (o_pos == three_q));

  always_comb begin
    stage1_next = '0;
    if (osc) begin
      stage1_next.ctrl.sel = wes_pkg::SEL_DRIVE;
    end else if (o_pos == '0) begin
      stage1_next.ctrl.sel = wes_pkg::SEL_DOWN;
    end else if (c_eff == '0) begin
      stage1_next.ctrl.sel = wes_pkg::SEL_RIGHT;
    end else if (o_pos == m_eff + PW'(1)) begin
      stage1_next.ctrl.sel = wes_pkg::SEL_UP;
    end else if (c_eff == m_eff + PW'(1)) begin
      stage1_next.ctrl.sel = wes_pkg::SEL_LEFT;
    end else begin
      stage1_next.ctrl.sel = wes_pkg::SEL_STENCIL;
    end
    stage1_next.ctrl.out_row = o_pos[wes_pkg::COORD_W-1:0];
    stage1_next.ctrl.out_col = c_eff[wes_pkg::COORD_W-1:0];
    stage1_next.ctrl.last    = flush_row && (col_inc == side);
    stage1_next.emit         = (r_eff != '0);
    stage1_next.store_write  = !flush_row;
    stage1_next.right_ok     = (col_inc < side);
    stage1_next.col          = c_eff[CW-1:0];
    stage1_next.down         = flush_row ? '0 : items.data.cur_value;
    stage1_next.drive        = first_cell ? items.data.drive_value : drive_latch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
    end else if (adv) begin
      stage1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      stage1 <= stage1_next;
    end
  end

  // Row above at column c-1: the center value of the previous transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_above <= '0;
    end else if (adv && stage1_valid) begin
      left_above <= above_rd_a;
    end
  end

  // --------------------------------------------------------------------
  // Line cell chain: the incoming value lands in the row-above cell; the
  // entry it replaces moves into the two-rows-above cell a stage later.
  // --------------------------------------------------------------------
  wes_line_cell #(
    .DEPTH (MAX_SIDE),
    .AW    (CW)
  ) u_above_cell (
    .clk       (clk),
    .we        (take && !flush_row),
    .wr_addr   (c_eff[CW-1:0]),
    .wr_data   (items.data.cur_value),
    .re        (take),
    .rd_addr_a (c_eff[CW-1:0]),
    .rd_addr_b (col_inc[CW-1:0]),
    .rd_data_a (above_rd_a),
    .rd_data_b (above_rd_b)
  );

  wes_line_cell #(
    .DEPTH (MAX_SIDE),
    .AW    (CW)
  ) u_two_above_cell (
    .clk       (clk),
    .we        (adv && stage1_valid && stage1.store_write),
    .wr_addr   (stage1.col),
    .wr_data   (above_rd_a),
    .re        (take),
    .rd_addr_a (c_eff[CW-1:0]),
    .rd_addr_b (c_eff[CW-1:0]),
    .rd_data_a (two_rd_a),
    .rd_data_b ()
  );

  wes_line_cell #(
    .DEPTH (MAX_SIDE),
    .AW    (CW)
  ) u_prior_cell (
    .clk       (clk),
    .we        (take && !flush_row),
    .wr_addr   (c_eff[CW-1:0]),
    .wr_data   (items.data.prior_value),
    .re        (take),
    .rd_addr_a (c_eff[CW-1:0]),
    .rd_addr_b (c_eff[CW-1:0]),
    .rd_data_a (prior_rd_a),
    .rd_data_b ()
  );

  // right neighbor beyond the last column reads as zero
  assign right_val = stage1.right_ok ? above_rd_b : '0;

  // --------------------------------------------------------------------
  // Stencil datapath and results register
  // --------------------------------------------------------------------
  wes_stencil_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (stage1_valid && stage1.emit),
    .ctrl      (stage1.ctrl),
    .left      (left_above),
    .right     (right_val),
    .center    (above_rd_a),
    .up        (two_rd_a),
    .down      (stage1.down),
    .prior     (prior_rd_a),
    .drive     (stage1.drive),
    .coeff     (courant_coeff),
    .out_valid (alu_valid),
    .result    (alu_result)
  );

  assign results.valid = alu_valid;
  assign results.data  = alu_result;

  // --------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------
  // The last cell of a frame is the bottom-right corner.
  `WES_ASSERT_NOW(a_last_is_corner, clk, rst, results.valid && results.data.last_of_frame, results.data.out_row == results.data.out_col)
  // The frame's final flush cell returns the position to the top-left corner.
  `WES_ASSERT_NOW(a_flush_wraps, clk, rst, stage1_valid && stage1.ctrl.last, (row_counter == '0) && (col_counter == '0))
  // The first cell of a frame samples the drive value.
  `WES_ASSERT_NEXT(a_drive_sampled, clk, rst, take && first_cell, drive_latch == $past(items.data.drive_value))

endmodule

`default_nettype wire
